@@ hdl/rarf_pkg.sv @@
// Package: shared constants, types and blend arithmetic for the RGB565 rectangle fill block.
package rarf_pkg;

    localparam int unsigned FRAME_WORDS_DEF = 262144;
    localparam int unsigned CMD_W   = 1;
    localparam int unsigned COORD_W = 11;
    localparam int unsigned DIM_W   = 10;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned ALPHA_W = 8;
    localparam int unsigned CNT_W   = 19;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 10;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [DIM_W-1:0] SURF_W_RST = 10'd320;
    localparam logic [DIM_W-1:0] SURF_H_RST = 10'd240;
    localparam logic [DIM_W-1:0] STRIDE_RST = 10'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SURF_W = 2'd0,
        REG_SURF_H = 2'd1,
        REG_STRIDE = 2'd2,
        REG_NONE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL = 1'b0,
        CMD_READ = 1'b1
    } cmd_kind_t;

    // Classified job handed from the front to the back end.
    typedef struct packed {
        cmd_kind_t         kind;
        logic              empty;   // nothing to touch
        logic [DIM_W:0]    x0;
        logic [DIM_W:0]    x1;
        logic [DIM_W:0]    y0;
        logic [DIM_W:0]    y1;
        logic [PIX_W-1:0]  color;
        logic [ALPHA_W-1:0] alpha;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_DONE
    } bk_state_t;

    // (v + 127) / 255 for v < 16193, so the quotient fits in six bits, by reciprocal and one correction.
    function automatic logic [5:0] div255(input logic [15:0] v);
        logic [16:0] s;
        logic [16:0] q;
        logic [16:0] r;
        begin
            s = {1'b0, v} + 17'd127;
            q = 17'((s + (s >> 8) + 17'd1) >> 8);
            r = 17'(s - 17'(q * 17'd255));
            if (r[16])
                q = q - 17'd1;
            div255 = q[5:0];
        end
    endfunction

endpackage

@@ hdl/rarf_if.sv @@
// Interfaces: valid/ready channels for commands, results and configuration writes.
interface rarf_cmd_if;
    import rarf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          kind;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]          rect_width;
    logic [DIM_W-1:0]          rect_height;
    logic [PIX_W-1:0]          fill_color;
    logic [ALPHA_W-1:0]        blend_alpha;
    modport source (output valid, kind, origin_x, origin_y, rect_width, rect_height,
                    fill_color, blend_alpha, input ready);
    modport sink (input valid, kind, origin_x, origin_y, rect_width, rect_height,
                  fill_color, blend_alpha, output ready);
endinterface

interface rarf_res_if;
    import rarf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] read_pixel;
    logic [CNT_W-1:0] pixels_written;
    modport source (output valid, read_pixel, pixels_written, input ready);
    modport sink (input valid, read_pixel, pixels_written, output ready);
endinterface

interface rarf_cfg_if;
    import rarf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/rarf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module rarf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

@@ hdl/rarf_front.sv @@
// Front end: accept commands and clip them against the surface.
module rarf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    rarf_cmd_if.sink                   cmd,
    input  logic [rarf_pkg::DIM_W-1:0] surf_w,
    input  logic [rarf_pkg::DIM_W-1:0] surf_h,
    output logic                       job_valid,
    input  logic                       job_ready,
    output rarf_pkg::job_t             job
);
    import rarf_pkg::*;

    logic signed [COORD_W+1:0] ex, ey, sx, sy;
    logic signed [COORD_W+1:0] cx0, cy0, cx1, cy1;
    job_t j;
    job_t job_reg;
    logic valid_reg;

    always_comb
    begin
        ex  = (COORD_W+2)'(cmd.origin_x);
        ey  = (COORD_W+2)'(cmd.origin_y);
        sx  = $signed({3'b000, surf_w});
        sy  = $signed({3'b000, surf_h});
        cx0 = ex[COORD_W+1] ? '0 : ex;
        cy0 = ey[COORD_W+1] ? '0 : ey;
        if (cmd.kind == CMD_READ)
        begin
            cx1 = ex + 13'sd1;
            cy1 = ey + 13'sd1;
        end
        else
        begin
            cx1 = ex + $signed({3'b000, cmd.rect_width});
            cy1 = ey + $signed({3'b000, cmd.rect_height});
        end
        if (cx1 > sx)
            cx1 = sx;
        if (cy1 > sy)
            cy1 = sy;
        j.kind  = cmd_kind_t'(cmd.kind);
        j.empty = (cx0 >= cx1) || (cy0 >= cy1) ||
                  ((cmd.kind == CMD_FILL) && (cmd.blend_alpha == '0));
        j.x0    = cx0[DIM_W:0];
        j.y0    = cy0[DIM_W:0];
        j.x1    = cx1[DIM_W:0];
        j.y1    = cy1[DIM_W:0];
        j.color = cmd.fill_color;
        j.alpha = cmd.blend_alpha;
    end

    assign cmd.ready = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.ready)
            valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            job_reg <= j;
    end
endmodule

@@ hdl/rarf_queue.sv @@
// Two-entry job queue between front and back end.
module rarf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rarf_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output rarf_pkg::job_t out_job
);
    import rarf_pkg::*;

    job_t buf_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = buf_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                wp_reg <= ~wp_reg;
            if (out_valid && out_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((in_valid && in_ready) ? 1 : 0)
                               - 2'((out_valid && out_ready) ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            buf_reg[wp_reg] <= in_job;
    end
endmodule

@@ hdl/rarf_back.sv @@
// Back end: walk the clipped rectangle, read-modify-write each pixel, emit results.
module rarf_back #(
    parameter int unsigned FRAME_WORDS = rarf_pkg::FRAME_WORDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  rarf_pkg::job_t             job,
    input  logic [rarf_pkg::DIM_W-1:0] stride,
    rarf_res_if.source                 res
);
    import rarf_pkg::*;

    localparam int unsigned AW = $clog2(FRAME_WORDS);
    localparam int unsigned LW = 2*DIM_W + 2;

    bk_state_t state_reg, state_next;
    job_t      j_reg;
    logic [DIM_W:0] x_reg, x_next, y_reg, y_next;
    logic [LW-1:0]  rowb_reg, rowb_next;     // y * stride
    // pipeline: stage 1 = memory read issued, stage 2 = blend and write
    logic           p1_reg, p1_next;
    logic [AW-1:0]  a1_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           rv_reg, rv_next;
    logic [PIX_W-1:0] rp_reg, rp_next;       // working pixel of the current job
    logic [PIX_W-1:0] ro_reg, ro_next;       // pixel of the result on offer
    logic [CNT_W-1:0] rc_reg, rc_next;

    logic [LW-1:0]  lin;
    logic           inmem;
    logic [AW-1:0]  addr;
    logic [PIX_W-1:0] rd_data, mixed;
    logic           wr_en;
    logic           last;
    logic [ALPHA_W-1:0] na;
    logic [15:0]    sr, sg, sb;
    logic [5:0]     qr, qg, qb;

    rarf_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_WORDS)) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(a1_reg),
        .wr_data(mixed),
        .rd_addr(addr),
        .rd_data(rd_data)
    );

    assign lin   = rowb_reg + LW'(x_reg);
    assign inmem = lin < LW'(FRAME_WORDS);
    assign addr  = lin[AW-1:0];
    assign last  = (x_reg + 1'b1 == j_reg.x1) && (y_reg + 1'b1 == j_reg.y1);

    // Blend one pixel; the immediately preceding write is forwarded when it hits the same word.
    logic [PIX_W-1:0] dst;
    logic [PIX_W-1:0] fwd_reg;
    logic             fwd_v_reg;
    logic [AW-1:0]    fwd_a_reg;
    assign dst = (fwd_v_reg && fwd_a_reg == a1_reg) ? fwd_reg : rd_data;

    always_comb
    begin
        na = 8'd255 - j_reg.alpha;
        sr = 16'(j_reg.color[15:11] * j_reg.alpha) + 16'(dst[15:11] * na);
        sg = 16'(j_reg.color[10:5] * j_reg.alpha) + 16'(dst[10:5] * na);
        sb = 16'(j_reg.color[4:0] * j_reg.alpha) + 16'(dst[4:0] * na);
        qr = div255(sr);
        qg = div255(sg);
        qb = div255(sb);
        if (j_reg.alpha == 8'd255)
            mixed = j_reg.color;
        else
            mixed = {qr[4:0], qg, qb[4:0]};
    end

    assign wr_en = p1_reg && (j_reg.kind == CMD_FILL);

    assign job_ready      = state_reg == BK_IDLE;
    assign res.valid      = rv_reg;
    assign res.read_pixel = ro_reg;
    assign res.pixels_written = rc_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rowb_next  = rowb_reg;
        p1_next    = 1'b0;
        cnt_next   = cnt_reg;
        rv_next    = rv_reg && !res.ready;
        rp_next    = rp_reg;
        ro_next    = ro_reg;
        rc_next    = rc_reg;
        if (p1_reg && j_reg.kind == CMD_FILL && cnt_reg != CNT_MAX)
            cnt_next = cnt_reg + 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    x_next    = job.x0;
                    y_next    = job.y0;
                    rowb_next = LW'(job.y0 * stride);
                    cnt_next  = '0;
                    rp_next   = '0;
                    state_next = job.empty ? BK_DONE : BK_RUN;
                end
            end
            BK_RUN:
            begin
                p1_next = inmem;
                if (last)
                    state_next = BK_DRAIN;
                else if (x_reg + 1'b1 == j_reg.x1)
                begin
                    x_next    = j_reg.x0;
                    y_next    = y_reg + 1'b1;
                    rowb_next = rowb_reg + LW'(stride);
                end
                else
                    x_next = x_reg + 1'b1;
            end
            BK_DRAIN:
            begin
                if (!p1_reg)
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!rv_reg || res.ready)
                begin
                    rv_next    = 1'b1;
                    ro_next    = rp_reg;
                    rc_next    = cnt_reg;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
        if (p1_reg && j_reg.kind == CMD_READ)
            rp_next = rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            p1_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            fwd_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p1_reg    <= p1_next;
            rv_reg    <= rv_next;
            fwd_v_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && job_valid)
            j_reg <= job;
        x_reg     <= x_next;
        y_reg     <= y_next;
        rowb_reg  <= rowb_next;
        a1_reg    <= addr;
        cnt_reg   <= cnt_next;
        rp_reg    <= rp_next;
        ro_reg    <= ro_next;
        rc_reg    <= rc_next;
        fwd_reg   <= mixed;
        fwd_a_reg <= a1_reg;
    end
endmodule

@@ hdl/rgb565_alpha_rect_fill_top.sv @@
// Top level: RGB565 framebuffer with alpha-blended rectangle fill and pixel read.
//
// Channels: cmd takes commands (fill a rectangle or read one pixel), res returns
// exactly one result per command in command order, cfg writes the surface width,
// surface height and row stride registers (index 0, 1, 2); the user must write
// them only while the block is idle, which the block itself does not enforce.
// A fill is clipped to the surface, then walked one pixel per cycle through a
// read-modify-write pipeline on the frame memory; a pixel whose word address lies
// beyond the memory is skipped and not counted.
// Flow: a command is registered in the front end, passes the queue, and the back
// end walks its covered pixels, drains the pipeline and then presents the result;
// an empty command skips the walk. Throughput is one pixel per cycle, set by the
// single memory port pair of the frame store; commands are carried out one at a time.
// The front end and a two-entry queue keep taking commands while the back end
// works or while a result waits for the receiver; when res stalls, the back end
// holds its finished result and the queue fills, then cmd.ready drops.
// Reset clears control state and loads the register defaults (320, 240, 320); the
// frame memory is undefined until software fills it.
module rgb565_alpha_rect_fill_top #(
    parameter int unsigned FRAME_WORDS = rarf_pkg::FRAME_WORDS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    rarf_cmd_if.sink   cmd,
    rarf_res_if.source res,
    rarf_cfg_if.sink   cfg
);
    import rarf_pkg::*;

    logic [DIM_W-1:0] surf_w_reg, surf_h_reg, stride_reg;
    logic  fj_valid, fj_ready, qj_valid, qj_ready;
    job_t  fj, qj;

    // Configuration writes always accepted; unknown index is dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surf_w_reg <= SURF_W_RST;
            surf_h_reg <= SURF_H_RST;
            stride_reg <= STRIDE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_SURF_W: surf_w_reg <= cfg.data;
                REG_SURF_H: surf_h_reg <= cfg.data;
                REG_STRIDE: stride_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    rarf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .surf_w   (surf_w_reg),
        .surf_h   (surf_h_reg),
        .job_valid(fj_valid),
        .job_ready(fj_ready),
        .job      (fj)
    );

    rarf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fj_valid),
        .in_ready (fj_ready),
        .in_job   (fj),
        .out_valid(qj_valid),
        .out_ready(qj_ready),
        .out_job  (qj)
    );

    rarf_back #(.FRAME_WORDS(FRAME_WORDS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(qj_valid),
        .job_ready(qj_ready),
        .job      (qj),
        .stride   (stride_reg),
        .res      (res)
    );
endmodule
